FILE: rtl/core/srld_pkg.sv
// Shared types and codes for the sprite frame RLE decoder.
package srld_pkg;

    // Request function codes
    localparam logic [1:0] FUNC_PAL   = 2'd0;
    localparam logic [1:0] FUNC_BYTE  = 2'd1;
    localparam logic [1:0] FUNC_START = 2'd2;

    // Result kinds
    localparam logic [1:0] KIND_PIXEL = 2'd0;
    localparam logic [1:0] KIND_DONE  = 2'd1;
    localparam logic [1:0] KIND_ERROR = 2'd2;

    // Error codes
    localparam logic [1:0] ERR_NONE     = 2'd0;
    localparam logic [1:0] ERR_MARKER   = 2'd1;
    localparam logic [1:0] ERR_OVERFLOW = 2'd2;
    localparam logic [1:0] ERR_EARLY    = 2'd3;

    // Configuration register indexes
    localparam logic [1:0] CFG_WIDTH  = 2'd0;
    localparam logic [1:0] CFG_HEIGHT = 2'd1;
    localparam logic [1:0] CFG_KEY    = 2'd2;
    localparam logic [1:0] CFG_RAW    = 2'd3;

    localparam int PAL_ENTRIES = 256;
    localparam int PAL_AW      = $clog2(PAL_ENTRIES);

    typedef struct packed {
        logic [1:0]  func;
        logic [7:0]  data_byte;
        logic        stream_end;
        logic [7:0]  pal_index;
        logic [31:0] pal_color;
    } srld_req_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] pix_x;
        logic [15:0] pix_y;
        logic [31:0] color_out;
        logic [1:0]  err_code;
    } srld_rsp_t;

    typedef struct packed {
        logic [15:0] frame_width;
        logic [15:0] frame_height;
        logic        key_color_enable;
        logic        raw_mode;
    } srld_cfg_t;

    // Parser phases, one-hot
    typedef enum logic [12:0] {
        PH_IDLE    = 13'b0000000000001,
        PH_RAW     = 13'b0000000000010,
        PH_PEND    = 13'b0000000000100,
        PH_MARK_LO = 13'b0000000001000,
        PH_MARK_HI = 13'b0000000010000,
        PH_ROW_LO  = 13'b0000000100000,
        PH_ROW_HI  = 13'b0000001000000,
        PH_CNT_LO  = 13'b0000010000000,
        PH_CNT_HI  = 13'b0000100000000,
        PH_SKP_LO  = 13'b0001000000000,
        PH_SKP_HI  = 13'b0010000000000,
        PH_PIX     = 13'b0100000000000,
        PH_PAD     = 13'b1000000000000
    } srld_phase_t;

endpackage

FILE: rtl/core/sprite_frame_rle_decoder.sv
// Sprite frame RLE decoder top level: request stage, palette, parser, result register.
// Takes one request per cycle unless the result side stalls, and gives at most one result per
// request. On acceptance a request is held in the request stage while the palette is read at
// its data byte (a palette write request is written at the same edge); once the result
// register is free, the parser updates its state and loads the result register. A stalled
// result blocks the request stage, and further requests, only once both are full.
// Configuration is written through cfg_we/cfg_index/cfg_data and must only change while the
// decoder is idle; mode and raw pixel total are sampled at frame start.
module sprite_frame_rle_decoder (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_ready,
    input  srld_pkg::srld_req_t req,
    output logic                rsp_valid,
    input  logic                rsp_ready,
    output srld_pkg::srld_rsp_t rsp,
    input  logic                cfg_we,
    input  logic [1:0]          cfg_index,
    input  logic [15:0]         cfg_data
);
    import srld_pkg::*;

    srld_cfg_t   cfg_reg;
    logic        s1_valid_reg;
    srld_req_t   s1_req_reg;
    logic        rsp_valid_reg;
    srld_rsp_t   rsp_reg;
    logic        accept;
    logic        fire;
    logic        hit;
    logic [31:0] pal_word;
    srld_rsp_t   rsp_calc;

    // handshake
    assign fire      = s1_valid_reg && (!rsp_valid_reg || rsp_ready);
    assign req_ready = !s1_valid_reg || fire;
    assign accept    = req_valid && req_ready;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.frame_width      <= 16'd1;
            cfg_reg.frame_height     <= 16'd1;
            cfg_reg.key_color_enable <= 1'b0;
            cfg_reg.raw_mode         <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_WIDTH:  cfg_reg.frame_width      <= cfg_data;
                CFG_HEIGHT: cfg_reg.frame_height     <= cfg_data;
                CFG_KEY:    cfg_reg.key_color_enable <= cfg_data[0];
                CFG_RAW:    cfg_reg.raw_mode         <= cfg_data[0];
                default:    cfg_reg                  <= cfg_reg;
            endcase
        end
    end

    // request stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (fire)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_req_reg <= req;
        end
    end

    // palette: written and read as the request is taken
    srld_palette u_palette (
        .clk      (clk),
        .wr_en    (accept && (req.func == FUNC_PAL)),
        .wr_index (req.pal_index),
        .wr_color (req.pal_color),
        .rd_en    (accept),
        .rd_index (req.data_byte),
        .rd_data  (pal_word)
    );

    srld_parser u_parser (
        .clk      (clk),
        .rst_n    (rst_n),
        .fire     (fire),
        .req      (s1_req_reg),
        .pal_word (pal_word),
        .cfg      (cfg_reg),
        .hit      (hit),
        .rsp      (rsp_calc)
    );

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (fire)
        begin
            rsp_valid_reg <= hit;
        end
        else if (rsp_ready)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire && hit)
        begin
            rsp_reg <= rsp_calc;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

`ifndef ASSERT_OFF
    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        !req_ready |-> (s1_valid_reg && rsp_valid_reg && !rsp_ready))
        else $error("request side stalled without a full pipeline");

    a_kind_legal: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (rsp.kind == KIND_PIXEL || rsp.kind == KIND_DONE ||
                       rsp.kind == KIND_ERROR))
        else $error("result kind out of range");

    a_status_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp.kind != KIND_PIXEL) |->
            (rsp.pix_x == 16'd0 && rsp.pix_y == 16'd0 && rsp.color_out == 32'd0))
        else $error("status result carries pixel data");

    a_error_coded: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> ((rsp.kind == KIND_ERROR) == (rsp.err_code != ERR_NONE)))
        else $error("error code does not match result kind");
`endif

endmodule

FILE: rtl/core/srld_palette.sv
// Palette memory: one write port, one read port with registered data.
module srld_palette (
    input  logic                      clk,
    input  logic                      wr_en,
    input  logic [srld_pkg::PAL_AW-1:0] wr_index,
    input  logic [31:0]               wr_color,
    input  logic                      rd_en,
    input  logic [srld_pkg::PAL_AW-1:0] rd_index,
    output logic [31:0]               rd_data
);
    import srld_pkg::*;

    logic [31:0] mem [PAL_ENTRIES];
    logic [31:0] rd_data_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_index] <= wr_color;
        end
    end

    // read port, captured with the request
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_index];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: rtl/core/srld_parser.sv
// Frame stream parser: decoder state and the per-request result.
module srld_parser (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                fire,
    input  srld_pkg::srld_req_t req,
    input  logic [31:0]         pal_word,
    input  srld_pkg::srld_cfg_t cfg,
    output logic                hit,
    output srld_pkg::srld_rsp_t rsp
);
    import srld_pkg::*;

    srld_phase_t phase_reg, phase_next;
    logic [16:0] col_reg, col_next;
    logic [16:0] row_reg, row_next;
    logic [15:0] run_count_reg, run_count_next;
    logic [15:0] run_skip_reg, run_skip_next;
    logic [7:0]  low_byte_reg, low_byte_next;
    logic [31:0] raw_remaining_reg, raw_remaining_next;

    logic [15:0] word;
    logic [16:0] col_inc;
    logic [16:0] row_sum;
    logic [17:0] span;
    logic [15:0] run_dec;
    logic [31:0] raw_dec;
    logic [31:0] raw_total;
    logic [31:0] pix_color;
    logic        is_err;
    logic        is_done;
    logic        is_pix;
    logic        finishing;
    logic [1:0]  err_val;

    // shared datapath terms
    assign word      = {req.data_byte, low_byte_reg};
    assign col_inc   = col_reg + 17'd1;
    assign row_sum   = row_reg + {1'b0, word};
    assign span      = {1'b0, col_reg} + {2'b00, word} + {2'b00, run_count_reg};
    assign run_dec   = run_count_reg - 16'd1;
    assign raw_dec   = raw_remaining_reg - 32'd1;
    assign raw_total = {16'd0, cfg.frame_width} * {16'd0, cfg.frame_height};
    assign pix_color = (cfg.key_color_enable && (req.data_byte == 8'd0)) ? 32'd0 : pal_word;

    // next state and result
    always_comb
    begin
        phase_next         = phase_reg;
        col_next           = col_reg;
        row_next           = row_reg;
        run_count_next     = run_count_reg;
        run_skip_next      = run_skip_reg;
        low_byte_next      = low_byte_reg;
        raw_remaining_next = raw_remaining_reg;
        is_err             = 1'b0;
        is_done            = 1'b0;
        is_pix             = 1'b0;
        finishing          = 1'b0;
        err_val            = ERR_NONE;
        hit                = 1'b0;
        rsp                = '0;

        // pending raw completion goes out ahead of anything else
        if (phase_reg == PH_PEND)
        begin
            hit        = 1'b1;
            rsp.kind   = KIND_DONE;
            phase_next = PH_IDLE;
        end

        if (req.func == FUNC_START)
        begin
            col_next       = '0;
            row_next       = '0;
            run_count_next = '0;
            run_skip_next  = '0;
            low_byte_next  = '0;
            if (cfg.raw_mode)
            begin
                raw_remaining_next = raw_total;
                phase_next = (raw_total != 32'd0) ? PH_RAW : PH_PEND;
            end
            else
            begin
                phase_next = PH_MARK_LO;
            end
        end
        else if (req.func == FUNC_BYTE && phase_reg != PH_PEND && phase_reg != PH_IDLE)
        begin
            case (phase_reg)
                PH_RAW:
                begin
                    is_pix             = 1'b1;
                    raw_remaining_next = raw_dec;
                    if (col_inc >= {1'b0, cfg.frame_width})
                    begin
                        col_next = '0;
                        row_next = row_reg + 17'd1;
                    end
                    else
                    begin
                        col_next = col_inc;
                    end
                    if (raw_dec == 32'd0)
                    begin
                        phase_next = PH_PEND;
                        finishing  = 1'b1;
                    end
                end
                PH_MARK_LO:
                begin
                    low_byte_next = req.data_byte;
                    phase_next    = PH_MARK_HI;
                end
                PH_ROW_LO:
                begin
                    low_byte_next = req.data_byte;
                    phase_next    = PH_ROW_HI;
                end
                PH_CNT_LO:
                begin
                    low_byte_next = req.data_byte;
                    phase_next    = PH_CNT_HI;
                end
                PH_SKP_LO:
                begin
                    low_byte_next = req.data_byte;
                    phase_next    = PH_SKP_HI;
                end
                PH_MARK_HI:
                begin
                    run_count_next = word;
                    phase_next     = PH_ROW_LO;
                end
                PH_ROW_HI:
                begin
                    row_next = {1'b0, word};
                    if (run_count_reg != 16'd1)
                    begin
                        is_err     = 1'b1;
                        err_val    = ERR_MARKER;
                        phase_next = PH_IDLE;
                    end
                    else if (word >= cfg.frame_height)
                    begin
                        is_done    = 1'b1;
                        phase_next = PH_IDLE;
                    end
                    else
                    begin
                        col_next   = '0;
                        phase_next = PH_CNT_LO;
                    end
                end
                PH_CNT_HI:
                begin
                    run_count_next = word;
                    phase_next     = PH_SKP_LO;
                end
                PH_SKP_HI:
                begin
                    if (run_count_reg == 16'd0)
                    begin
                        // row skip record
                        row_next = row_sum;
                        col_next = '0;
                        if (row_sum >= {1'b0, cfg.frame_height})
                        begin
                            is_done    = 1'b1;
                            phase_next = PH_IDLE;
                        end
                        else
                        begin
                            phase_next = PH_CNT_LO;
                        end
                    end
                    else if (span > {2'b00, cfg.frame_width})
                    begin
                        is_err     = 1'b1;
                        err_val    = ERR_OVERFLOW;
                        phase_next = PH_IDLE;
                    end
                    else
                    begin
                        col_next      = col_reg + {1'b0, word};
                        run_skip_next = run_count_reg;
                        phase_next    = PH_PIX;
                    end
                end
                PH_PIX:
                begin
                    is_pix         = 1'b1;
                    col_next       = col_inc;
                    run_count_next = run_dec;
                    if (run_dec == 16'd0)
                    begin
                        if (run_skip_reg[0])
                        begin
                            phase_next = PH_PAD;
                        end
                        else
                        begin
                            if (col_inc >= {1'b0, cfg.frame_width})
                            begin
                                col_next = '0;
                            end
                            phase_next = PH_CNT_LO;
                        end
                    end
                end
                PH_PAD:
                begin
                    if (col_reg >= {1'b0, cfg.frame_width})
                    begin
                        col_next = '0;
                    end
                    phase_next = PH_CNT_LO;
                end
                default:
                begin
                    phase_next = PH_IDLE;
                end
            endcase

            // result priority: error or done, then early end, then pixel
            if (is_err || is_done)
            begin
                hit          = 1'b1;
                rsp.kind     = is_err ? KIND_ERROR : KIND_DONE;
                rsp.err_code = err_val;
            end
            else if (req.stream_end && !finishing)
            begin
                hit          = 1'b1;
                phase_next   = PH_IDLE;
                rsp.kind     = KIND_ERROR;
                rsp.err_code = ERR_EARLY;
            end
            else if (is_pix)
            begin
                hit           = 1'b1;
                rsp.kind      = KIND_PIXEL;
                rsp.pix_x     = col_reg[15:0];
                rsp.pix_y     = row_reg[15:0];
                rsp.color_out = pix_color;
            end
        end
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg         <= PH_IDLE;
            col_reg           <= '0;
            row_reg           <= '0;
            run_count_reg     <= '0;
            run_skip_reg      <= '0;
            low_byte_reg      <= '0;
            raw_remaining_reg <= '0;
        end
        else if (fire)
        begin
            phase_reg         <= phase_next;
            col_reg           <= col_next;
            row_reg           <= row_next;
            run_count_reg     <= run_count_next;
            run_skip_reg      <= run_skip_next;
            low_byte_reg      <= low_byte_next;
            raw_remaining_reg <= raw_remaining_next;
        end
    end

endmodule
